### hw/rtl/btpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int APB_AW = 5;
    localparam int APB_DW = 64;

    localparam logic [33:0] FINE_OFFSET = 34'd128000;
    localparam logic [63:0] DIV_SCALE   = 64'd3125;
    localparam logic [63:0] PRESS_BASE  = 64'd1048576;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;
    localparam logic [63:0] V1_BIAS     = 64'h0000_8000_0000_0000;

    localparam int DIV_BITS = 64;

    typedef enum logic [1:0] {
        REG_TEMP_CALIB = 2'd0,
        REG_PRESS_A    = 2'd1,
        REG_PRESS_B    = 2'd2,
        REG_PRESS_C    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [19:0] temp_reading;
        logic [19:0] press_reading;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temp_centi_degc;
        logic [31:0]        press_q24_8;
        logic               divisor_zero;
    } out_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } calib_t;

    typedef struct packed {
        logic [31:0] temp;
        logic [33:0] v1;
        logic [19:0] praw;
    } tmp2prs_t;

    typedef struct packed {
        logic [63:0] num;
        logic [63:0] den;
        logic [31:0] temp;
    } prs2div_t;

    typedef struct packed {
        logic [63:0] quot;
        logic [31:0] temp;
        logic        dz;
    } div2post_t;

endpackage

### hw/rtl/baro_temp_press_compensation_top.sv
`timescale 1ns / 1ps
// Stages from an accepted input beat to its result beat
//   (5 temperature, 5 pressure front end, 66 divider, 4 correction stages).
// Throughput: one beat per cycle unless stalled; the divider sets the depth.
// The whole pipeline holds while a result beat waits on m_ready.
// Reset (synchronous, aresetn low) clears all valid bits and the calibration
//   registers to zero; no clearing pass.
// ----------------------------------------------------------------------------
// baro_temp_press_compensation_top
// Barometric temperature and pressure compensation pipeline with an
// APB-style calibration register port.
// ----------------------------------------------------------------------------
module baro_temp_press_compensation_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  btpc_pkg::in_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output btpc_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btpc_pkg::APB_AW-1:0]   paddr,
    input  logic [btpc_pkg::APB_DW-1:0]   pwdata,
    output logic [btpc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import btpc_pkg::*;

    // Calibration registers, one 64-bit slot per register (address = 8 * index)
    logic [47:0] temp_calib_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_c_reg;
    logic        wr_en;
    reg_idx_t    idx;
    calib_t      calib;

    // Global advance: every stage moves when the result register is free
    // or its beat is being taken.
    logic adv;

    logic               tmp_valid, prs_valid, div_valid;
    tmp2prs_t           tmp_data;
    prs2div_t           prs_data;
    div2post_t          div_data;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_a_reg    <= '0;
            press_b_reg    <= '0;
            press_c_reg    <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_TEMP_CALIB: temp_calib_reg <= pwdata[47:0];
                REG_PRESS_A:    press_a_reg    <= pwdata;
                REG_PRESS_B:    press_b_reg    <= pwdata;
                REG_PRESS_C:    press_c_reg    <= pwdata[15:0];
                default:        press_c_reg    <= press_c_reg;
            endcase
        end
    end

    // Read back, zero-extended
    always_comb begin
        unique case (idx)
            REG_TEMP_CALIB: prdata = {16'd0, temp_calib_reg};
            REG_PRESS_A:    prdata = press_a_reg;
            REG_PRESS_B:    prdata = press_b_reg;
            REG_PRESS_C:    prdata = {48'd0, press_c_reg};
            default:        prdata = '0;
        endcase
    end

    // Unpack the calibration words
    always_comb begin
        calib.t1 = temp_calib_reg[15:0];
        calib.t2 = temp_calib_reg[31:16];
        calib.t3 = temp_calib_reg[47:32];
        calib.p1 = press_a_reg[15:0];
        calib.p2 = press_a_reg[31:16];
        calib.p3 = press_a_reg[47:32];
        calib.p4 = press_a_reg[63:48];
        calib.p5 = press_b_reg[15:0];
        calib.p6 = press_b_reg[31:16];
        calib.p7 = press_b_reg[47:32];
        calib.p8 = press_b_reg[63:48];
        calib.p9 = press_c_reg;
    end

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Fine temperature and centi-degree output
    btpc_temp u_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .calib     (calib),
        .out_valid (tmp_valid),
        .out_data  (tmp_data)
    );

    // Dividend and divisor for the pressure quotient
    btpc_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (tmp_valid),
        .in_data   (tmp_data),
        .calib     (calib),
        .out_valid (prs_valid),
        .out_data  (prs_data)
    );

    // Signed divide, one quotient bit per stage
    btpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (prs_valid),
        .in_data   (prs_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // Second-order correction; holds the result register
    btpc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .calib     (calib),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // A zero divisor always forces a zero pressure
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.divisor_zero |-> m_data.press_q24_8 == 32'd0)
        else $error("divisor_zero set with nonzero pressure");

    // A waiting result blocks the input side
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while pipeline stalled");

    // No result beat right after reset
    a_rst: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // A held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

endmodule

### hw/rtl/btpc_temp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_temp
// Five-stage 32-bit fine temperature pipeline; emits centi-degrees and the
// offset fine term for the pressure path.
// ----------------------------------------------------------------------------
module btpc_temp (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  btpc_pkg::in_t     in_data,
    input  btpc_pkg::calib_t  calib,
    output logic              out_valid,
    output btpc_pkg::tmp2prs_t out_data
);
    import btpc_pkg::*;

    logic [4:0]  vld_reg;
    logic [19:0] praw_reg [5];

    logic [31:0] a_reg, b_reg, a_next, b_next;
    logic [31:0] m1_reg, bb_reg, m1_next, bb_next;
    logic [31:0] v1t_reg, m2_reg, v1t_next, m2_next, bbs;
    logic [31:0] fine_reg, fine_next;
    logic [31:0] temp_reg, temp_next, t5;
    logic [33:0] v1_reg, v1_next;

    always_comb begin
        a_next  = {15'd0, in_data.temp_reading[19:3]} - {15'd0, calib.t1, 1'b0};
        b_next  = {16'd0, in_data.temp_reading[19:4]} - {16'd0, calib.t1};
        m1_next = a_reg * {{16{calib.t2[15]}}, calib.t2};
        bb_next = b_reg * b_reg;
        v1t_next = $signed(m1_reg) >>> 11;
        bbs      = $signed(bb_reg) >>> 12;
        m2_next  = bbs * {{16{calib.t3[15]}}, calib.t3};
        fine_next = v1t_reg + 32'($signed(m2_reg) >>> 14);
        t5        = fine_reg * 32'd5 + TEMP_ROUND;
        temp_next = $signed(t5) >>> 8;
        v1_next   = {{2{fine_reg[31]}}, fine_reg} - FINE_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            m1_reg   <= m1_next;
            bb_reg   <= bb_next;
            v1t_reg  <= v1t_next;
            m2_reg   <= m2_next;
            fine_reg <= fine_next;
            temp_reg <= temp_next;
            v1_reg   <= v1_next;
            praw_reg[0] <= in_data.press_reading;
            for (int i = 1; i < 5; i++) begin
                praw_reg[i] <= praw_reg[i-1];
            end
        end
    end

    assign out_valid     = vld_reg[4];
    assign out_data.temp = temp_reg;
    assign out_data.v1   = v1_reg;
    assign out_data.praw = praw_reg[4];

endmodule

### hw/rtl/btpc_press.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_press
// Five-stage 64-bit pressure front end: builds the dividend and divisor.
// ----------------------------------------------------------------------------
module btpc_press (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  btpc_pkg::tmp2prs_t in_data,
    input  btpc_pkg::calib_t   calib,
    output logic               out_valid,
    output btpc_pkg::prs2div_t out_data
);
    import btpc_pkg::*;

    logic [4:0]  vld_reg;
    logic [31:0] temp_reg [5];
    logic [19:0] praw_reg [3];

    logic [63:0] sq_reg, mv2_reg, mv5_reg, sq_next, mv2_next, mv5_next;
    logic [63:0] x6_reg, x3_reg, mv2b_reg, mv5b_reg, x6_next, x3_next;
    logic [63:0] v2_reg, v1b_reg, v2_next, v1b_next, x3s;
    logic [63:0] v1c_reg, num0_reg, v1c_next, num0_next, pcomp;
    logic [63:0] den_reg, num_reg, den_next, num_next;

    always_comb begin
        sq_next  = 64'($signed(in_data.v1)) * 64'($signed(in_data.v1));
        mv2_next = 64'($signed(in_data.v1)) * 64'($signed(calib.p2));
        mv5_next = 64'($signed(in_data.v1)) * 64'($signed(calib.p5));
        x6_next  = $signed(sq_reg) * 64'($signed(calib.p6));
        x3_next  = $signed(sq_reg) * 64'($signed(calib.p3));
        v2_next  = x6_reg + (mv5b_reg << 17) + ({{48{calib.p4[15]}}, calib.p4} << 35);
        x3s      = $signed(x3_reg) >>> 8;
        v1b_next = x3s + (mv2b_reg << 12);
        v1c_next = (V1_BIAS + v1b_reg) * {48'd0, calib.p1};
        pcomp    = PRESS_BASE - {44'd0, praw_reg[2]};
        num0_next = (pcomp << 31) - v2_reg;
        den_next = $signed(v1c_reg) >>> 33;
        num_next = num0_reg * DIV_SCALE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_reg   <= sq_next;
            mv2_reg  <= mv2_next;
            mv5_reg  <= mv5_next;
            x6_reg   <= x6_next;
            x3_reg   <= x3_next;
            mv2b_reg <= mv2_reg;
            mv5b_reg <= mv5_reg;
            v2_reg   <= v2_next;
            v1b_reg  <= v1b_next;
            v1c_reg  <= v1c_next;
            num0_reg <= num0_next;
            den_reg  <= den_next;
            num_reg  <= num_next;
            temp_reg[0] <= in_data.temp;
            for (int i = 1; i < 5; i++) begin
                temp_reg[i] <= temp_reg[i-1];
            end
            praw_reg[0] <= in_data.praw;
            for (int i = 1; i < 3; i++) begin
                praw_reg[i] <= praw_reg[i-1];
            end
        end
    end

    assign out_valid     = vld_reg[4];
    assign out_data.num  = num_reg;
    assign out_data.den  = den_reg;
    assign out_data.temp = temp_reg[4];

endmodule

### hw/rtl/btpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined signed 64-bit divider, truncating toward zero: magnitude stage,
// one restoring quotient bit per stage, sign fix stage.
// ----------------------------------------------------------------------------
module btpc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  btpc_pkg::prs2div_t  in_data,
    output logic                out_valid,
    output btpc_pkg::div2post_t out_data
);
    import btpc_pkg::*;

    logic [DIV_BITS+1:0] vld_reg;
    logic [63:0] rem_reg  [DIV_BITS+1];
    logic [63:0] quo_reg  [DIV_BITS+1];
    logic [63:0] den_reg  [DIV_BITS+1];
    logic        neg_reg  [DIV_BITS+1];
    logic        dz_reg   [DIV_BITS+1];
    logic [31:0] temp_reg [DIV_BITS+1];

    logic [63:0] quot_reg, quot_next;
    logic [31:0] tout_reg;
    logic        dzout_reg;
    logic [63:0] num_abs, den_abs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DIV_BITS:0], in_valid};
        end
    end

    // magnitudes and result sign
    always_comb begin
        num_abs = in_data.num[63] ? 64'd0 - in_data.num : in_data.num;
        den_abs = in_data.den[63] ? 64'd0 - in_data.den : in_data.den;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0]  <= '0;
            quo_reg[0]  <= num_abs;
            den_reg[0]  <= den_abs;
            neg_reg[0]  <= in_data.num[63] ^ in_data.den[63];
            dz_reg[0]   <= (in_data.den == 64'd0);
            temp_reg[0] <= in_data.temp;
        end
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
        logic [64:0] shifted;
        logic [64:0] diff;
        logic        ge;
        always_comb begin
            shifted = {rem_reg[k], quo_reg[k][63]};
            diff    = shifted - {1'b0, den_reg[k]};
            ge      = !diff[64];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k+1]  <= ge ? diff[63:0] : shifted[63:0];
                quo_reg[k+1]  <= {quo_reg[k][62:0], ge};
                den_reg[k+1]  <= den_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                dz_reg[k+1]   <= dz_reg[k];
                temp_reg[k+1] <= temp_reg[k];
            end
        end
    end

    assign quot_next = neg_reg[DIV_BITS] ? 64'd0 - quo_reg[DIV_BITS] : quo_reg[DIV_BITS];

    always_ff @(posedge aclk) begin
        if (adv) begin
            quot_reg  <= quot_next;
            tout_reg  <= temp_reg[DIV_BITS];
            dzout_reg <= dz_reg[DIV_BITS];
        end
    end

    assign out_valid     = vld_reg[DIV_BITS+1];
    assign out_data.quot = quot_reg;
    assign out_data.temp = tout_reg;
    assign out_data.dz   = dzout_reg;

endmodule

### hw/rtl/btpc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_post
// Four-stage pressure correction after the divide; last stage is the
// result register.
// ----------------------------------------------------------------------------
module btpc_post (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  btpc_pkg::div2post_t in_data,
    input  btpc_pkg::calib_t    calib,
    output logic                out_valid,
    output btpc_pkg::out_t      out_data
);
    import btpc_pkg::*;

    logic [3:0]  vld_reg;
    logic [31:0] temp_reg [4];
    logic        dz_reg   [4];

    logic [63:0] q_next, pq_next, c2m_next;
    logic [63:0] p1_reg, q_reg, pq_reg, c2m1_reg;
    logic [63:0] ll_reg, p2_reg, c2m2_reg, ll_next;
    logic [31:0] lh_reg, hl_reg, lh_next, hl_next;
    logic [63:0] c1_reg, c2s_reg, c1_next, c2s_next;
    logic [39:0] p3_reg, c1s, sum40;
    logic [31:0] press_reg, press_next;

    always_comb begin
        q_next   = $signed(in_data.quot) >>> 13;
        pq_next  = 64'($signed(calib.p9)) * $signed(q_next);
        c2m_next = 64'($signed(calib.p8)) * $signed(in_data.quot);
        ll_next  = {32'd0, pq_reg[31:0]} * {32'd0, q_reg[31:0]};
        lh_next  = pq_reg[31:0] * q_reg[63:32];
        hl_next  = pq_reg[63:32] * q_reg[31:0];
        c1_next  = ll_reg + {lh_reg + hl_reg, 32'd0};
        c2s_next = $signed(c2m2_reg) >>> 19;
        c1s      = 40'($signed(c1_reg) >>> 25);
        sum40    = p3_reg + c1s + c2s_reg[39:0];
        press_next = sum40[39:8] + ({{16{calib.p7[15]}}, calib.p7} << 4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg   <= in_data.quot;
            q_reg    <= q_next;
            pq_reg   <= pq_next;
            c2m1_reg <= c2m_next;
            ll_reg   <= ll_next;
            lh_reg   <= lh_next;
            hl_reg   <= hl_next;
            p2_reg   <= p1_reg;
            c2m2_reg <= c2m1_reg;
            c1_reg   <= c1_next;
            c2s_reg  <= c2s_next;
            p3_reg   <= p2_reg[39:0];
            press_reg <= dz_reg[2] ? 32'd0 : press_next;
            temp_reg[0] <= in_data.temp;
            dz_reg[0]   <= in_data.dz;
            for (int i = 1; i < 4; i++) begin
                temp_reg[i] <= temp_reg[i-1];
                dz_reg[i]   <= dz_reg[i-1];
            end
        end
    end

    assign out_valid                = vld_reg[3];
    assign out_data.temp_centi_degc = temp_reg[3];
    assign out_data.press_q24_8     = press_reg;
    assign out_data.divisor_zero    = dz_reg[3];

endmodule
